// ----- rtl/cholesky_decomposition_macros.svh -----
// Assertion macros for the Cholesky block
`ifndef CHOLESKY_DECOMPOSITION_MACROS_SVH
`define CHOLESKY_DECOMPOSITION_MACROS_SVH

// implication checked on every clock edge out of reset
`define CHD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked on the clock after the antecedent
`define CHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/chd_pkg.sv -----
package chd_pkg;
    localparam int MAX_SIZE  = 8;
    localparam int FRAC_BITS = 24;
    localparam int IDX_W     = 3;
    localparam int CELLS     = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W    = 6;
    localparam int ACC_W     = 48;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0]
    {
        OP_SQRT = 2'd0,
        OP_DIV  = 2'd1
    } op_t;

    typedef struct packed
    {
        logic        start;
        op_t         op;
        logic [55:0] num;
        logic [31:0] den;
    } cu_req_t;

    typedef struct packed
    {
        logic        done;
        logic [31:0] res;
    } cu_rsp_t;

    function automatic addr_t cell_addr(idx_t r, idx_t c);
        return {r, c};
    endfunction
endpackage

// ----- rtl/cholesky_decomposition.sv -----
// Cholesky factor block, lower factor, signed Q8.24.
// Input channel (in_valid/in_ready): one matrix element per item, tagged with
// row_index and col_index; elements above the diagonal are dropped. An item
// with load_done set starts the factorization of the matrix_size x
// matrix_size lower triangle.
// Config channel (cfg_valid/cfg_ready): writes matrix_size; write only when idle.
// Loading accepts one item per cycle. After the last item the block is busy:
// each factor entry reads and accumulates each inner product term in turn, then
// takes one pass through the shared root/divide unit (a root on the diagonal,
// a divide below it).
// Output channel (out_valid/out_ready): n*n items row-major, zero above the
// diagonal, last_out on the final one; each item takes a memory read state
// (ST_ORD) and then a present state (ST_OUT). A stalled receiver holds
// the block in output, with no input taken.
// Reset: matrix_size becomes 7, block idle and ready for items; matrix
// contents are undefined until loaded.
module cholesky_decomposition
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         matrix_size,
    input  logic               in_valid,
    output logic               in_ready,
    input  chd_pkg::idx_t      row_index,
    input  chd_pkg::idx_t      col_index,
    input  logic signed [31:0] element_value,
    input  logic               load_done,
    output logic               out_valid,
    input  logic               out_ready,
    output chd_pkg::idx_t      out_row,
    output chd_pkg::idx_t      out_col,
    output logic signed [31:0] factor_value,
    output logic               last_out
);
    import chd_pkg::*;

    logic [3:0] size_reg;
    cu_req_t    cu_req;
    cu_rsp_t    cu_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= 4'd7;
        else if (cfg_valid)
            size_reg <= matrix_size;
    end

    chd_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .load_done     (load_done),
        .size          (size_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .factor_value  (factor_value),
        .last_out      (last_out),
        .cu_req        (cu_req),
        .cu_rsp        (cu_rsp)
    );

    chd_root_div u_cu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cu_req),
        .rsp   (cu_rsp)
    );
endmodule

// ----- rtl/chd_root_div.sv -----
module chd_root_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  chd_pkg::cu_req_t  req,
    output chd_pkg::cu_rsp_t  rsp
);
    import chd_pkg::*;

    // Shared bit-serial unit: restoring square root (2 bits per step, 28 steps)
    // or restoring division (1 quotient bit per step, 56 steps).
    logic        busy_reg;
    op_t         op_reg;
    logic [5:0]  cnt_reg;
    logic [55:0] num_reg;
    logic [31:0] den_reg;
    logic [57:0] rem_reg;
    logic [56:0] q_reg;
    logic        done_reg;

    logic [57:0] trial;
    logic [57:0] rem_sh;
    logic        ge;

    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh = {rem_reg[55:0], num_reg[55:54]};
            trial  = {q_reg[55:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[56:0], num_reg[55]};
            trial  = {26'd0, den_reg};
        end
        ge = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= (req.op == OP_SQRT) ? 6'd27 : 6'd55;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg  <= req.op;
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
                num_reg <= {num_reg[53:0], 2'b00};
            else
                num_reg <= {num_reg[54:0], 1'b0};
            rem_reg <= ge ? rem_sh - trial : rem_sh;
            q_reg   <= {q_reg[55:0], ge};
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (op_reg == OP_DIV && q_reg >= 57'h1_0000_0000)
            rsp.res = 32'h8000_0000;
        else
            rsp.res = q_reg[31:0];
    end
endmodule

// ----- rtl/chd_ctrl.sv -----
`include "cholesky_decomposition_macros.svh"

module chd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  chd_pkg::idx_t     row_index,
    input  chd_pkg::idx_t     col_index,
    input  logic signed [31:0] element_value,
    input  logic              load_done,
    input  logic [3:0]        size,
    output logic              out_valid,
    input  logic              out_ready,
    output chd_pkg::idx_t     out_row,
    output chd_pkg::idx_t     out_col,
    output logic signed [31:0] factor_value,
    output logic              last_out,
    output chd_pkg::cu_req_t  cu_req,
    input  chd_pkg::cu_rsp_t  cu_rsp
);
    import chd_pkg::*;

    typedef enum logic [9:0]
    {
        ST_LOAD  = 10'b0000000001,
        ST_INIT  = 10'b0000000010,
        ST_RDA   = 10'b0000000100,
        ST_RDK   = 10'b0000001000,
        ST_MUL   = 10'b0000010000,
        ST_ACC   = 10'b0000100000,
        ST_START = 10'b0001000000,
        ST_WAIT  = 10'b0010000000,
        ST_ORD   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] a_mem [CELLS];
    logic [31:0] l_mem [CELLS];

    idx_t        n1_reg;
    idx_t        i_reg, j_reg, k_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [31:0] a_rd_reg, li_reg, l_rd_reg;
    logic [63:0] prod_reg;
    logic        rd_half_reg;
    logic        ov_reg;
    logic signed [31:0] sum_sat_reg;
    logic        neg_reg;

    logic [3:0]  n_eff;
    logic signed [63:0] prod_rnd;
    logic signed [ACC_W-1:0] acc_s;
    logic signed [31:0] sum_sat;
    logic        diag;
    addr_t       l_rd_addr;
    logic        l_we;
    logic [31:0] l_wdata;
    logic [31:0] cu_q;

    assign diag = i_reg == j_reg;
    assign in_ready = state_reg == ST_LOAD;
    assign acc_s = acc_reg;

    always_comb
    begin
        n_eff = size;
        if (n_eff == 4'd0)
            n_eff = 4'd1;
        if (n_eff > 4'(MAX_SIZE))
            n_eff = 4'(MAX_SIZE);
    end

    always_comb
    begin
        if (acc_s > 48'sd2147483647)
            sum_sat = 32'sh7fff_ffff;
        else if (acc_s < -48'sd2147483648)
            sum_sat = 32'sh8000_0000;
        else
            sum_sat = acc_s[31:0];
    end

    assign prod_rnd = ($signed(prod_reg) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

    always_comb
    begin
        cu_req.start = state_reg == ST_START;
        cu_req.op    = diag ? OP_SQRT : OP_DIV;
        cu_req.den   = ($signed(l_rd_reg) < 32'sd1) ? 32'd1 : l_rd_reg;
        if (diag)
            cu_req.num = {(sum_sat_reg < 32'sd1) ? 32'd1 : 32'(sum_sat_reg), 24'd0};
        else
            cu_req.num = {neg_reg ? 32'(-33'(sum_sat_reg)) : 32'(sum_sat_reg), 24'd0};
    end

    always_comb
    begin
        cu_q = cu_rsp.res;
        if (!diag && neg_reg)
            cu_q = 32'(-33'({cu_rsp.res == 32'h8000_0000 && ov_reg, cu_rsp.res}));
        if (!diag && cu_rsp.res[31] && !(neg_reg && cu_rsp.res == 32'h8000_0000))
            cu_q = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        l_we    = state_reg == ST_WAIT && cu_rsp.done;
        l_wdata = cu_q;
    end

    always_comb
    begin
        case (state_reg)
            ST_RDK:  l_rd_addr = rd_half_reg ? cell_addr(j_reg, k_reg)
                                             : cell_addr(i_reg, k_reg);
            ST_ACC:  l_rd_addr = cell_addr(j_reg, j_reg);
            ST_ORD, ST_OUT:
                     l_rd_addr = cell_addr(i_reg, j_reg);
            default: l_rd_addr = cell_addr(j_reg, j_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && col_index <= row_index)
            a_mem[cell_addr(row_index, col_index)] <= element_value;
        a_rd_reg <= a_mem[cell_addr(i_reg, j_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
            l_mem[cell_addr(i_reg, j_reg)] <= l_wdata;
        l_rd_reg <= l_mem[l_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_RDA:
                acc_reg <= {{(ACC_W-32){a_rd_reg[31]}}, a_rd_reg};
            ST_MUL:
                prod_reg <= 64'($signed(li_reg)) * 64'($signed(l_rd_reg));
            ST_ACC:
                if (k_reg != j_reg)
                    acc_reg <= acc_reg - prod_rnd[ACC_W-1:0];
            ST_START:
            begin
                sum_sat_reg <= sum_sat_reg;
            end
            default:
            begin
            end
        endcase
        if (state_reg == ST_RDK && rd_half_reg)
            li_reg <= l_rd_reg;
        if (state_reg == ST_ACC && k_reg == j_reg)
        begin
            sum_sat_reg <= sum_sat;
            neg_reg     <= sum_sat < 0;
            ov_reg      <= 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (in_valid && load_done) state_next = ST_INIT;
            ST_INIT:  state_next = ST_RDA;
            ST_RDA:   state_next = (j_reg == 3'd0) ? ST_ACC : ST_RDK;
            ST_RDK:   state_next = rd_half_reg ? ST_MUL : ST_RDK;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = (k_reg == j_reg) ? ST_START : ST_RDK;
            ST_START: state_next = ST_WAIT;
            ST_WAIT:
                if (cu_rsp.done)
                begin
                    if (diag && i_reg == n1_reg)
                        state_next = ST_ORD;
                    else
                        state_next = ST_INIT;
                end
            ST_ORD:   state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = (i_reg == n1_reg && j_reg == n1_reg) ? ST_LOAD : ST_ORD;
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            n1_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            rd_half_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_LOAD:
                    if (in_valid && load_done)
                    begin
                        n1_reg <= 3'(n_eff - 4'd1);
                        i_reg  <= '0;
                        j_reg  <= '0;
                    end
                ST_INIT:
                begin
                    k_reg       <= '0;
                    rd_half_reg <= 1'b0;
                end
                ST_RDK:
                    rd_half_reg <= !rd_half_reg;
                ST_ACC:
                    if (k_reg != j_reg)
                        k_reg <= k_reg + 3'd1;
                ST_WAIT:
                    if (cu_rsp.done)
                    begin
                        if (diag)
                        begin
                            if (i_reg == n1_reg)
                            begin
                                i_reg <= '0;
                                j_reg <= '0;
                            end
                            else
                            begin
                                i_reg <= i_reg + 3'd1;
                                j_reg <= '0;
                            end
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                ST_OUT:
                    if (out_ready)
                    begin
                        if (j_reg == n1_reg)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 3'd1;
                        end
                        else
                            j_reg <= j_reg + 3'd1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = state_reg == ST_OUT;
    assign out_row      = i_reg;
    assign out_col      = j_reg;
    assign factor_value = (j_reg <= i_reg) ? l_rd_reg : 32'sd0;
    assign last_out     = i_reg == n1_reg && j_reg == n1_reg;

    `CHD_ASSERT_IMP(a_no_in_busy, clk, rst_n, state_reg != ST_LOAD, !in_ready)
    `CHD_ASSERT_IMP(a_j_le_i, clk, rst_n, state_reg == ST_WAIT, j_reg <= i_reg)
    `CHD_ASSERT_IMP(a_k_le_j, clk, rst_n, state_reg == ST_ACC, k_reg <= j_reg)
    `CHD_ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_ready && last_out, in_ready)
endmodule
